[rtl/core/njd_pkg.sv]
// Shared types and codes for the non-preemptive job dispatcher.
// No dependencies.
package njd_pkg;

	localparam int ID_W    = 6;
	localparam int BURST_W = 16;
	localparam int OFF_W   = 16;
	localparam int TIME_W  = 32;
	localparam int RC_W    = 7;
	localparam int KIND_W  = 2;
	localparam int POL_W   = 2;

	// command codes
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DISP   = 2'd3;

	// dispatch policies (any other code acts as arrival order)
	localparam logic [POL_W-1:0] POL_FCFS  = 2'd0;
	localparam logic [POL_W-1:0] POL_SJF   = 2'd1;
	localparam logic [POL_W-1:0] POL_LOWID = 2'd2;

	typedef struct packed {
		logic               command;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
		logic [OFF_W-1:0]   response_offset;
	} in_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   out_job_id;
		logic [TIME_W-1:0] start_tick;
		logic [TIME_W-1:0] finish_tick;
		logic [TIME_W-1:0] wait_time;
		logic [TIME_W-1:0] turnaround_ticks;
		logic [TIME_W-1:0] response_ticks;
		logic [RC_W-1:0]   ready_count;
	} out_beat_t;

endpackage

[rtl/core/njd_front.sv]
// Front end: two-entry command queue that takes input beats and hands
// them to the back end. Depends on njd_pkg.
module njd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  njd_pkg::in_beat_t in_data,
	output logic              q_valid,
	output njd_pkg::in_beat_t q_beat,
	input  logic              pop
);
	import njd_pkg::*;

	in_beat_t   fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_ready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_beat   = fifo_q[rp_q];
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/core/njd_back.sv]
// Back end: ready store in a memory, scan for the best job, compaction
// sweep, time keeping and the registered result beat. Depends on njd_pkg.
module njd_back #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [njd_pkg::POL_W-1:0]        policy,
	input  logic                             q_valid,
	input  njd_pkg::in_beat_t                q_beat,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output njd_pkg::out_beat_t               out_data
);
	import njd_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CALC, S_SHIFT, S_DONE} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
		logic [OFF_W-1:0]   offset;
		logic [TIME_W-1:0]  arrival;
	} slot_t;

	slot_t             mem [QUEUE_DEPTH];
	slot_t             rdata_q;
	slot_t             best_q;
	slot_t             wr_data;
	state_t            st_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     nx_q;
	logic [CW-1:0]     cnt_m1;
	logic [AW-1:0]     ri_q;
	logic [AW-1:0]     bidx_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              rv_q;
	logic [TIME_W-1:0] now_q;
	logic              busy_q;
	logic [TIME_W-1:0] busy_until_q;
	logic [TIME_W-1:0] fin_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] rs_q;
	logic              ovalid_q;
	out_beat_t         out_q;
	out_beat_t         plain_res;

	logic out_free;
	logic rd_en;
	logic is_full;
	logic arr_wr;
	logic sh_wr;
	logic better;
	logic release_now;
	logic can_disp;
	logic scan_last;
	logic shift_done;
	logic res_load;

	assign out_valid  = ovalid_q;
	assign out_data   = out_q;
	assign out_free   = !ovalid_q || out_ready;
	assign pop        = (st_q == S_IDLE) && q_valid && out_free;
	assign rd_en      = ((st_q == S_SCAN) || (st_q == S_SHIFT)) && (nx_q < cnt_q);
	assign rd_addr    = nx_q[AW-1:0];
	assign is_full    = (cnt_q == DEPTH_C);
	assign arr_wr     = pop && (q_beat.command == CMD_ARRIVE) && !is_full;
	assign sh_wr      = (st_q == S_SHIFT) && rv_q;
	assign cnt_m1     = cnt_q - CW'(1);
	assign scan_last  = rv_q && (ri_q == cnt_m1[AW-1:0]);
	assign shift_done = (st_q == S_SHIFT) && !rd_en && !rv_q;
	assign release_now = busy_q && (now_q == busy_until_q);
	assign can_disp   = (!busy_q || release_now) && (cnt_q != '0);
	// a result beat is loaded on every popped beat except a dispatching tick,
	// which loads its result from S_DONE
	assign res_load   = (pop && !((q_beat.command == CMD_TICK) && can_disp))
	                  || ((st_q == S_DONE) && out_free);

	always_comb begin
		wr_addr = sh_wr ? (ri_q - AW'(1)) : cnt_q[AW-1:0];
		if (sh_wr) begin
			wr_data = rdata_q;
		end else begin
			wr_data.job_id  = q_beat.job_id;
			wr_data.burst   = q_beat.burst;
			wr_data.offset  = q_beat.response_offset;
			wr_data.arrival = now_q;
		end
	end

	// result of an arrival or of a tick that dispatches nothing
	always_comb begin
		plain_res = '0;
		if (q_beat.command == CMD_ARRIVE) begin
			plain_res.kind        = is_full ? KIND_DROP : KIND_ACCEPT;
			plain_res.ready_count = is_full ? RC_W'(cnt_q) : RC_W'(cnt_q + CW'(1));
		end else begin
			plain_res.kind        = KIND_IDLE;
			plain_res.ready_count = RC_W'(cnt_q);
		end
	end

	// strict compare keeps the earliest arrival on ties
	always_comb begin
		unique case (policy)
			POL_SJF:   better = (rdata_q.burst < best_q.burst);
			POL_LOWID: better = (rdata_q.job_id < best_q.job_id);
			default:   better = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (arr_wr || sh_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			cnt_q        <= '0;
			nx_q         <= '0;
			ri_q         <= '0;
			rv_q         <= 1'b0;
			bidx_q       <= '0;
			best_q       <= '0;
			now_q        <= '0;
			busy_q       <= 1'b0;
			busy_until_q <= '0;
			fin_q        <= '0;
			wait_q       <= '0;
			rs_q         <= '0;
			ovalid_q     <= 1'b0;
			out_q        <= '0;
		end else begin
			rv_q <= rd_en;
			if (rd_en) begin
				ri_q <= rd_addr;
			end
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (pop) begin
						if (q_beat.command == CMD_ARRIVE) begin
							out_q <= plain_res;
							if (!is_full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else begin
							if (release_now) begin
								busy_q <= 1'b0;
							end
							if (can_disp) begin
								nx_q <= '0;
								st_q <= S_SCAN;
							end else begin
								out_q <= plain_res;
								now_q <= now_q + TIME_W'(1);
							end
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						nx_q <= nx_q + CW'(1);
					end
					if (rv_q && ((ri_q == '0) || better)) begin
						best_q <= rdata_q;
						bidx_q <= ri_q;
					end
					if (scan_last) begin
						st_q <= S_CALC;
					end
				end
				S_CALC: begin
					fin_q  <= now_q + TIME_W'(best_q.burst);
					wait_q <= now_q - best_q.arrival;
					rs_q   <= now_q + TIME_W'(best_q.offset);
					nx_q   <= CW'(bidx_q) + CW'(1);
					st_q   <= S_SHIFT;
				end
				S_SHIFT: begin
					if (rd_en) begin
						nx_q <= nx_q + CW'(1);
					end
					if (shift_done) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.kind             <= KIND_DISP;
						out_q.out_job_id       <= best_q.job_id;
						out_q.start_tick       <= now_q;
						out_q.finish_tick      <= fin_q;
						out_q.wait_time        <= wait_q;
						out_q.turnaround_ticks <= fin_q - best_q.arrival;
						out_q.response_ticks   <= rs_q - best_q.arrival;
						out_q.ready_count      <= RC_W'(cnt_m1);
						cnt_q                  <= cnt_m1;
						busy_q                 <= (best_q.burst != '0);
						busy_until_q           <= fin_q;
						now_q                  <= now_q + TIME_W'(1);
						st_q                   <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("ready count above store depth");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SHIFT && rv_q) |-> (ri_q != '0))
		else $error("compaction write below slot zero");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN) |-> (cnt_q != '0))
		else $error("scan of an empty store");

	a_done_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DONE && out_free) |=> (cnt_q == $past(cnt_m1)))
		else $error("dispatch did not remove one job");

endmodule

[rtl/core/non_preemptive_job_dispatcher_top.sv]
// Arrival or non-dispatching tick: the beat is registered in the front queue, then its result
// in the result register. Dispatching tick: the beat is queued, the store scanned, the times
// formed, the slots behind the pick compacted, and the result loaded. Throughput: one arrival
// per cycle when idle and unstalled; dispatch is bound by the store's single read port.
// Reset (arst_n low, async): time, busy state, job count, queue and policy go to zero.
module non_preemptive_job_dispatcher_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [njd_pkg::POL_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  njd_pkg::in_beat_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output njd_pkg::out_beat_t         out_data
);
	import njd_pkg::*;

	// policy register; the user writes it only while the block is quiet, which the block does not enforce
	logic [POL_W-1:0] policy_q;

	// front-to-back command queue
	logic     q_valid;
	in_beat_t q_beat;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	// front: takes beats while the back end is busy scanning or compacting
	njd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_beat   (q_beat),
		.pop      (pop)
	);

	// back: ready store, selection, time keeping, result register
	njd_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.q_valid   (q_valid),
		.q_beat    (q_beat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
